[rtl/core/hs_pkg.sv]
// Shared types and constants for the heap sorter.
package hs_pkg;

    // Store size and key width
    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 16;
    localparam int KEY_FIELD_W = 16;
    localparam int POS_W       = 6;
    localparam int STORE_W     = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CHILD_W     = ADDR_W + 2;

    // Input item
    typedef struct packed {
        logic [KEY_FIELD_W-1:0] key;
        logic                   last_item;
    } key_item_t;

    // Result item
    typedef struct packed {
        logic [KEY_FIELD_W-1:0] sorted_key;
        logic [POS_W-1:0]       position;
        logic                   end_of_run;
        logic                   overflowed;
    } res_item_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_SORT_RD,
        S_EXTRACT,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_OUT_RD,
        S_OUT
    } state_t;

endpackage

[rtl/core/heap_sorter.sv]
// Heap sorter: loads keys into a max-heap in RAM, heap-sorts in place, streams ascending keys.
// Load: a key is taken only in idle, then sifted up, reading the parent and comparing per level.
// Sort: each extraction reads root and tail, moves the root to the tail and sifts the tail key
//   down, reading both children per level, as the single RAM write port and registered reads demand.
// Output: each result is read, then held until taken; no key is taken meanwhile.
// Reset clears the sequencer, the load count and the overflow flag; the key RAM is not cleared.
module heap_sorter
    import hs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_ready,
    input  key_item_t key_item,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_item
);

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic               last_reg, last_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [STORE_W-1:0] cur_reg, cur_next;

    // Key RAM: one write port, two registered read ports
    logic [STORE_W-1:0] mem [DEPTH];
    logic [STORE_W-1:0] rd_a_reg, rd_b_reg;
    logic               mem_we, rd_a_en, rd_b_en;
    logic [ADDR_W-1:0]  mem_wa, rd_a_addr, rd_b_addr;
    logic [STORE_W-1:0] mem_wd;

    // Index helpers
    logic [ADDR_W-1:0]  parent;
    logic [CHILD_W-1:0] left_w, right_w, size_w;
    logic               use_right;
    logic [STORE_W-1:0] child_val;
    logic [ADDR_W-1:0]  child_addr;
    logic               key_acc, res_acc, last_out;

    assign key_acc = key_valid && key_ready;
    assign res_acc = res_valid && res_ready;

    assign parent  = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign left_w  = (CHILD_W'(pos_reg) << 1) + CHILD_W'(1);
    assign right_w = left_w + CHILD_W'(1);
    assign size_w  = CHILD_W'(size_reg);

    // Larger child; right only counts when it lies inside the heap
    assign use_right  = (right_w < size_w) && (rd_b_reg > rd_a_reg);
    assign child_val  = use_right ? rd_b_reg : rd_a_reg;
    assign child_addr = use_right ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];

    assign last_out = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    // Result item straight from the read register, held while waiting
    assign res_valid           = (state_reg == S_OUT);
    assign key_ready           = (state_reg == S_IDLE);
    assign res_item.sorted_key = KEY_FIELD_W'(rd_a_reg);
    assign res_item.position   = POS_W'(idx_reg);
    assign res_item.end_of_run = last_out;
    assign res_item.overflowed = dropped_reg;

    // RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            last_reg    <= 1'b0;
            pos_reg     <= '0;
            size_reg    <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            last_reg    <= last_next;
            pos_reg     <= pos_next;
            size_reg    <= size_next;
            idx_reg     <= idx_next;
        end
    end

    // Value being sifted
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        size_next    = size_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        mem_we       = 1'b0;
        mem_wa       = pos_reg;
        mem_wd       = cur_reg;
        rd_a_en      = 1'b0;
        rd_a_addr    = '0;
        rd_b_en      = 1'b0;
        rd_b_addr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (key_acc)
                begin
                    last_next = key_item.last_item;
                    if (count_reg < CNT_W'(DEPTH))
                    begin
                        // Insert: hole starts at the end of the heap
                        cur_next   = key_item.key[STORE_W-1:0];
                        pos_next   = ADDR_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        // Store full: key dropped
                        dropped_next = 1'b1;
                        size_next    = count_reg;
                        state_next   = key_item.last_item ? S_SORT_RD : S_IDLE;
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    size_next  = count_reg;
                    state_next = last_reg ? S_SORT_RD : S_IDLE;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cur_reg > rd_a_reg)
                begin
                    // Smaller parent moves down into the hole
                    mem_wd     = rd_a_reg;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    size_next  = count_reg;
                    state_next = last_reg ? S_SORT_RD : S_IDLE;
                end
            end

            S_SORT_RD:
            begin
                if (size_reg <= CNT_W'(1))
                begin
                    idx_next   = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = '0;
                    rd_b_en    = 1'b1;
                    rd_b_addr  = ADDR_W'(size_reg - CNT_W'(1));
                    state_next = S_EXTRACT;
                end
            end

            S_EXTRACT:
            begin
                // Root max goes to the tail; tail key sifts down from the root
                mem_we     = 1'b1;
                mem_wa     = ADDR_W'(size_reg - CNT_W'(1));
                mem_wd     = rd_a_reg;
                cur_next   = rd_b_reg;
                size_next  = size_reg - CNT_W'(1);
                pos_next   = '0;
                state_next = S_DOWN_RD;
            end

            S_DOWN_RD:
            begin
                if (left_w >= size_w)
                begin
                    mem_we     = 1'b1;
                    state_next = S_SORT_RD;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = left_w[ADDR_W-1:0];
                    rd_b_en    = 1'b1;
                    rd_b_addr  = right_w[ADDR_W-1:0];
                    state_next = S_DOWN_CMP;
                end
            end

            S_DOWN_CMP:
            begin
                mem_we = 1'b1;
                if (child_val > cur_reg)
                begin
                    // Larger child moves up into the hole
                    mem_wd     = child_val;
                    pos_next   = child_addr;
                    state_next = S_DOWN_RD;
                end
                else
                begin
                    state_next = S_SORT_RD;
                end
            end

            S_OUT_RD:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = idx_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (res_acc)
                begin
                    if (last_out)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/hs_check.sv]
// Port-level checker for the heap sorter, bound to the top level.
module hs_check
    import hs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      key_valid,
    input logic      key_ready,
    input key_item_t key_item,
    input logic      res_valid,
    input logic      res_ready,
    input res_item_t res_item
);

    // A waiting result holds its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");

    // Loading and streaming never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(key_ready && res_valid))
        else $error("key taken while a result is shown");

    // A key without the last mark causes no result right away
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready && !key_item.last_item |=> !res_valid)
        else $error("result after a key that is not last");

    // Ranks count up by one within a run
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_item.end_of_run |->
            ##2 (res_valid && res_item.position == POS_W'($past(res_item.position, 2) + 1)))
        else $error("rank did not advance by one");

    // After the final result the block returns to loading
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_item.end_of_run |=> !res_valid && key_ready)
        else $error("block did not return to loading after end of run");

endmodule

bind heap_sorter hs_check u_hs_check (.*);

[sim/heap_sorter_tb.sv]
// Testbench for heap_sorter: directed and random key sets checked against a heap-sort predictor.
module heap_sorter_tb;
    import hs_pkg::*;

    localparam int TOTAL_TARGET = 280;
    localparam int HOLD_AT      = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int QUIET_LIMIT  = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      key_valid = 1'b0;
    logic      key_ready;
    key_item_t key_item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_item_t res_item;

    // Items waiting to be offered, results still to arrive
    key_item_t pending_keys [$];
    res_item_t ascending_q [$];

    // Predictor state
    logic [STORE_W-1:0] heap_mem [DEPTH];
    int                 heap_cnt = 0;
    bit                 heap_drop = 1'b0;

    int n_total = 0;
    int keys_sent = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int err_cnt = 0;
    int quiet_cycles = 0;
    int tx_idle_pct;
    int rx_idle_pct;

    heap_sorter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_item  (key_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Load one key into the max-heap; on the last key, sort and queue the ascending results
    task automatic heap_load(input key_item_t it);
        logic [STORE_W-1:0] k;
        logic [STORE_W-1:0] top;
        logic [STORE_W-1:0] tmp;
        logic [STORE_W-1:0] ranked [DEPTH];
        int                 pos;
        int                 par;
        int                 size;
        int                 big;
        int                 lft;
        int                 n;
        res_item_t          r;
        begin
            k = it.key[STORE_W-1:0];
            if (heap_cnt < DEPTH)
            begin
                pos = heap_cnt;
                heap_mem[pos] = k;
                while (pos > 0)
                begin
                    par = (pos - 1) / 2;
                    if (heap_mem[pos] <= heap_mem[par])
                        break;
                    tmp = heap_mem[pos];
                    heap_mem[pos] = heap_mem[par];
                    heap_mem[par] = tmp;
                    pos = par;
                end
                heap_cnt++;
            end
            else
            begin
                // store full: key dropped
                heap_drop = 1'b1;
            end

            if (it.last_item)
            begin
                n = heap_cnt;
                size = n;
                // extract the maximum repeatedly, filling ranks from the top
                while (size > 0)
                begin
                    top = heap_mem[0];
                    size--;
                    heap_mem[0] = heap_mem[size];
                    pos = 0;
                    while (1)
                    begin
                        lft = 2 * pos + 1;
                        big = pos;
                        if (lft < size && heap_mem[lft] > heap_mem[big])
                            big = lft;
                        if (lft + 1 < size && heap_mem[lft + 1] > heap_mem[big])
                            big = lft + 1;
                        if (big == pos)
                            break;
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[big];
                        heap_mem[big] = tmp;
                        pos = big;
                    end
                    ranked[size] = top;
                end
                for (int i = 0; i < n; i++)
                begin
                    r = '0;
                    r.sorted_key = ranked[i];
                    r.position   = i[POS_W-1:0];
                    r.end_of_run = (i == n - 1);
                    r.overflowed = heap_drop;
                    ascending_q.push_back(r);
                end
                heap_cnt = 0;
                heap_drop = 1'b0;
            end
        end
    endtask

    task automatic push_key(input logic [KEY_FIELD_W-1:0] k, input logic last);
        key_item_t it;
        begin
            it.key = k;
            it.last_item = last;
            pending_keys.push_back(it);
        end
    endtask

    // Random set; some sets draw from a tiny range so duplicates show up
    task automatic push_set(input int len);
        bit narrow;
        begin
            narrow = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++)
            begin
                if (narrow)
                    push_key(KEY_FIELD_W'($urandom_range(0, 7)), i == len - 1);
                else
                    push_key(KEY_FIELD_W'($urandom), i == len - 1);
            end
        end
    endtask

    // Idle rates by stage: sender light / receiver heavy, swapped, then none
    always_comb
    begin
        if (keys_sent < n_total / 3)
        begin
            tx_idle_pct = 32;
            rx_idle_pct = 56;
        end
        else if (keys_sent < (2 * n_total) / 3)
        begin
            tx_idle_pct = 56;
            rx_idle_pct = 32;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid <= 1'b0;
            key_item  <= '0;
        end
        else
        begin
            if (key_valid && key_ready)
            begin
                heap_load(key_item);
                keys_sent <= keys_sent + 1;
            end
            if (key_valid && !key_ready)
            begin
                // hold the offered item
            end
            else if (pending_keys.size() != 0 &&
                     (hold_left > 0 || $urandom_range(0, 99) >= tx_idle_pct))
            begin
                key_valid <= 1'b1;
                key_item  <= pending_keys.pop_front();
            end
            else
            begin
                key_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen <= results_seen + 1;
                if (ascending_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result %p", $time, res_item);
                end
                else
                begin
                    if (res_item.sorted_key !== ascending_q[0].sorted_key)
                    begin
                        err_cnt++;
                        $display("%0t: sorted_key expected %h actual %h", $time,
                                 ascending_q[0].sorted_key, res_item.sorted_key);
                    end
                    if (res_item.position !== ascending_q[0].position)
                    begin
                        err_cnt++;
                        $display("%0t: position expected %0d actual %0d", $time,
                                 ascending_q[0].position, res_item.position);
                    end
                    if (res_item.end_of_run !== ascending_q[0].end_of_run)
                    begin
                        err_cnt++;
                        $display("%0t: end_of_run expected %b actual %b", $time,
                                 ascending_q[0].end_of_run, res_item.end_of_run);
                    end
                    if (res_item.overflowed !== ascending_q[0].overflowed)
                    begin
                        err_cnt++;
                        $display("%0t: overflowed expected %b actual %b", $time,
                                 ascending_q[0].overflowed, res_item.overflowed);
                    end
                    void'(ascending_q.pop_front());
                end
            end

            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_ready <= 1'b0;
            end
            else if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side
    always @(posedge clk)
    begin
        if (!rst_n || (key_valid && key_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("heap_sorter: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and end of run
    initial
    begin
        int set_idx;
        int len;

        // single keys at both extremes
        push_key(16'h0000, 1'b1);
        push_key(16'hFFFF, 1'b1);
        // extremes, midpoints and duplicates
        push_key(16'hFFFF, 1'b0);
        push_key(16'h0000, 1'b0);
        push_key(16'h8000, 1'b0);
        push_key(16'h7FFF, 1'b0);
        push_key(16'h8000, 1'b0);
        push_key(16'h0000, 1'b1);
        // descending arrival
        push_key(16'd50, 1'b0);
        push_key(16'd40, 1'b0);
        push_key(16'd30, 1'b0);
        push_key(16'd20, 1'b0);
        push_key(16'd10, 1'b1);
        // ascending arrival
        push_key(16'h0001, 1'b0);
        push_key(16'h0002, 1'b0);
        push_key(16'h0004, 1'b0);
        push_key(16'hFFFE, 1'b1);
        // all keys equal
        push_key(16'h5A5A, 1'b0);
        push_key(16'h5A5A, 1'b0);
        push_key(16'h5A5A, 1'b1);

        // random sets: mostly short, some near full size, including one exactly full and one overflowing
        set_idx = 0;
        while (pending_keys.size() < TOTAL_TARGET)
        begin
            if (set_idx == 2)
                len = DEPTH;
            else if (set_idx == 5)
                len = DEPTH + 3;
            else if ($urandom_range(0, 11) == 0)
                len = $urandom_range(DEPTH - 4, DEPTH + 8);
            else
                len = $urandom_range(1, 12);
            push_set(len);
            set_idx++;
        end
        n_total = pending_keys.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (keys_sent < n_total || ascending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ascending_q.size() != 0)
        begin
            err_cnt++;
            $display("%0t: %0d results never arrived", $time, ascending_q.size());
        end
        if (err_cnt == 0)
            $display("heap_sorter: match");
        else
            $display("heap_sorter: mismatch");
        $finish;
    end

endmodule

[heap_sorter.f]
rtl/core/hs_pkg.sv
rtl/core/heap_sorter.sv
rtl/core/hs_check.sv
sim/heap_sorter_tb.sv
